/* hdl/bcsh_pkg.sv */
// ----------------------------------------------------------------------------
// Bit-count class sequence histogram package
// Shared sizes, operation codes and the word classing functions.
// ----------------------------------------------------------------------------
package bcsh_pkg;

    localparam int MAX_TERMS    = 6;
    localparam int LOG_BUCKETS  = 2;
    localparam int WARMUP_WORDS = 4;
    localparam int COUNT_BITS   = 40;

    localparam int CODE_BITS   = LOG_BUCKETS * MAX_TERMS;
    localparam int BINS        = 1 << CODE_BITS;
    localparam int WARM_BITS   = $clog2(WARMUP_WORDS + 1);
    localparam int TERMS_BITS  = 3;
    localparam int ONES_BITS   = 6;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [WARM_BITS-1:0]  WARM_DONE = WARM_BITS'(WARMUP_WORDS);

    // Upper bit counts of the low and middle classes
    localparam logic [ONES_BITS-1:0] LOW_LIMIT = 6'd14;
    localparam logic [ONES_BITS-1:0] MID_LIMIT = 6'd17;

    typedef enum logic [0:0] {
        OP_SAMPLE = 1'b0,
        OP_READ   = 1'b1
    } op_t;

    typedef enum logic [LOG_BUCKETS-1:0] {
        CLASS_LOW  = 2'd0,
        CLASS_MID  = 2'd1,
        CLASS_HIGH = 2'd2
    } class_t;

    // Tree count of set bits in a 32-bit word
    function automatic logic [ONES_BITS-1:0] ones_in(input logic [31:0] v);
        logic [31:0] s;
        begin
            s = (v & 32'h5555_5555) + ((v >> 1) & 32'h5555_5555);
            s = (s & 32'h3333_3333) + ((s >> 2) & 32'h3333_3333);
            s = (s & 32'h0f0f_0f0f) + ((s >> 4) & 32'h0f0f_0f0f);
            s = (s & 32'h00ff_00ff) + ((s >> 8) & 32'h00ff_00ff);
            s = (s & 32'h0000_ffff) + ((s >> 16) & 32'h0000_ffff);
            return s[ONES_BITS-1:0];
        end
    endfunction

    function automatic class_t class_of(input logic [ONES_BITS-1:0] n);
        begin
            if (n <= LOW_LIMIT)
                return CLASS_LOW;
            else if (n <= MID_LIMIT)
                return CLASS_MID;
            else
                return CLASS_HIGH;
        end
    endfunction

    // Code mask for a terms setting; zero acts as one, large values clamp
    function automatic logic [CODE_BITS-1:0] code_mask(input logic [TERMS_BITS-1:0] t);
        logic [CODE_BITS-1:0] m;
        logic [TERMS_BITS-1:0] tc;
        begin
            tc = t;
            if (tc == '0)
                tc = TERMS_BITS'(1);
            m = '0;
            for (int i = 0; i < MAX_TERMS; i++)
            begin
                if (i < int'(tc))
                    m[i*LOG_BUCKETS +: LOG_BUCKETS] = '1;
            end
            return m;
        end
    endfunction

endpackage

/* hdl/bitcount_class_sequence_histogram.sv */
// ----------------------------------------------------------------------------
// Bit-count class sequence histogram
// Classes the bit count of w ^ (w << 1) for each sampled word, builds a code
// from the last few classes and counts codes in a saturating histogram RAM.
// ----------------------------------------------------------------------------
//
//  channel   signals                                   direction
//  -------   ---------------------------------------   ---------
//  request   in_valid, in_stall, operation, word,      in
//            bin_index
//  result    out_valid, out_stall, history_code,       out
//            counted, bin_count
//  config    config_write, config_data (terms)         in
//
// One request per cycle sustained while in_stall is low; a taken request reads
// the RAM, then updates and writes back in the update stage, and its result is queued.
// The histogram lives in one 4096 x 40 RAM with a registered read; a write of the
// previous request is forwarded to a request reading the same bin.
// After reset the RAM is cleared through all 4096 bins; in_stall holds meanwhile.
// A two-entry result queue lets requests flow while out_stall is high; the
// request side stalls once the queued results plus the one in the update
// stage reach two, so at most two requests are taken during a hold-off.
//
module bitcount_class_sequence_histogram
    import bcsh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  config_write,
    input  logic [TERMS_BITS-1:0] config_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [0:0]            operation,
    input  logic [31:0]           word,
    input  logic [11:0]           bin_index,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [11:0]           history_code,
    output logic                  counted,
    output logic [COUNT_BITS-1:0] bin_count
);

    // ------------------------------------------------------------------
    // Control and configuration state
    // ------------------------------------------------------------------
    logic [TERMS_BITS-1:0] terms_reg;
    logic [CODE_BITS-1:0]  history_reg, history_next;
    logic [WARM_BITS-1:0]  warm_reg, warm_next;
    logic                  clear_reg;
    logic [CODE_BITS-1:0]  clr_addr_reg;

    // Update stage: the request whose RAM data arrives this cycle
    logic                  e_valid_reg;
    op_t                   e_op_reg;
    logic [CODE_BITS-1:0]  e_addr_reg;
    logic [CODE_BITS-1:0]  e_code_reg;
    logic                  e_counted_reg;

    // Forward of the most recent RAM update
    logic                  fwd_valid_reg;
    logic [CODE_BITS-1:0]  fwd_addr_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;

    // Result queue, entry 0 is the head
    logic [1:0]            occ_reg, occ_next;
    logic [CODE_BITS-1:0]  q_code_reg    [0:1];
    logic                  q_counted_reg [0:1];
    logic [COUNT_BITS-1:0] q_count_reg   [0:1];
    logic [CODE_BITS-1:0]  q_code_next   [0:1];
    logic                  q_counted_next[0:1];
    logic [COUNT_BITS-1:0] q_count_next  [0:1];

    // Histogram RAM
    logic [COUNT_BITS-1:0] hist_mem [0:BINS-1];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [CODE_BITS-1:0]  rd_addr;
    logic                  mem_we;
    logic [CODE_BITS-1:0]  mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;

    logic                  accept;
    logic                  pop;
    logic [1:0]            occ_after;
    op_t                   op_in;
    logic [31:0]           mixed;
    class_t                cls;
    logic                  warm_full;
    logic                  upd_write;
    logic [COUNT_BITS-1:0] cur_count;
    logic [COUNT_BITS-1:0] inc_count;
    logic [0:0]            push_pos;

    // ------------------------------------------------------------------
    // Handshake: room exists if the queue, after this cycle's update
    // result and pop, still has a free slot for this request next cycle
    // ------------------------------------------------------------------
    assign pop       = (occ_reg != 2'd0) && !out_stall;
    assign occ_after = occ_reg + {1'b0, e_valid_reg} - {1'b0, pop};
    assign in_stall  = clear_reg || (occ_after > 2'd1);
    assign accept    = in_valid && !in_stall;
    assign op_in     = op_t'(operation);

    // ------------------------------------------------------------------
    // Sample classing and history code
    // ------------------------------------------------------------------
    assign mixed     = word ^ {word[30:0], 1'b0};
    assign cls       = class_of(ones_in(mixed));
    assign warm_full = (warm_reg == WARM_DONE);

    always_comb
    begin
        history_next = history_reg;
        warm_next    = warm_reg;
        if (accept && op_in == OP_SAMPLE)
        begin
            history_next = ({history_reg[CODE_BITS-LOG_BUCKETS-1:0], {LOG_BUCKETS{1'b0}}}
                            & code_mask(terms_reg))
                           | {{(CODE_BITS-LOG_BUCKETS){1'b0}}, cls};
            if (!warm_full)
                warm_next = warm_reg + WARM_BITS'(1);
        end
    end

    // Reads look up the requested bin, samples the bin of the new code
    assign rd_addr = (op_in == OP_READ) ? bin_index[CODE_BITS-1:0] : history_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            terms_reg    <= TERMS_BITS'(MAX_TERMS);
            history_reg  <= '0;
            warm_reg     <= '0;
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
            e_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            occ_reg      <= '0;
        end
        else
        begin
            if (config_write)
                terms_reg <= config_data;
            history_reg <= history_next;
            warm_reg    <= warm_next;
            if (clear_reg)
            begin
                clr_addr_reg <= clr_addr_reg + CODE_BITS'(1);
                if (clr_addr_reg == CODE_BITS'(BINS - 1))
                    clear_reg <= 1'b0;
            end
            e_valid_reg <= accept;
            if (upd_write)
                fwd_valid_reg <= 1'b1;
            occ_reg <= occ_next;
        end
    end

    // Update stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            e_op_reg      <= op_in;
            e_addr_reg    <= rd_addr;
            e_code_reg    <= history_next;
            e_counted_reg <= (op_in == OP_SAMPLE) && warm_full;
        end
        if (upd_write)
        begin
            fwd_addr_reg <= e_addr_reg;
            fwd_data_reg <= inc_count;
        end
    end

    // ------------------------------------------------------------------
    // Read-modify-write: take the forwarded count when the previous update
    // hit the same bin, since the RAM read raced that write
    // ------------------------------------------------------------------
    assign cur_count = (fwd_valid_reg && fwd_addr_reg == e_addr_reg) ? fwd_data_reg
                                                                     : rd_data_reg;
    assign inc_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_BITS'(1);
    assign upd_write = e_valid_reg && e_counted_reg;

    assign mem_we    = clear_reg || upd_write;
    assign mem_waddr = clear_reg ? clr_addr_reg : e_addr_reg;
    assign mem_wdata = clear_reg ? '0 : inc_count;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            hist_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= hist_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Result queue: drop the head on pop, append the update result
    // ------------------------------------------------------------------
    assign push_pos = occ_after[0] ^ e_valid_reg;

    always_comb
    begin
        q_code_next    = q_code_reg;
        q_counted_next = q_counted_reg;
        q_count_next   = q_count_reg;
        if (pop)
        begin
            q_code_next[0]    = q_code_reg[1];
            q_counted_next[0] = q_counted_reg[1];
            q_count_next[0]   = q_count_reg[1];
        end
        if (e_valid_reg)
        begin
            q_code_next[push_pos]    = e_code_reg;
            q_counted_next[push_pos] = e_counted_reg;
            q_count_next[push_pos]   = (e_op_reg == OP_READ) ? cur_count : '0;
        end
        occ_next = occ_after;
    end

    always_ff @(posedge clk)
    begin
        q_code_reg    <= q_code_next;
        q_counted_reg <= q_counted_next;
        q_count_reg   <= q_count_next;
    end

    assign out_valid    = (occ_reg != 2'd0);
    assign history_code = q_code_reg[0];
    assign counted      = q_counted_reg[0];
    assign bin_count    = q_count_reg[0];

`ifndef SYNTHESIS
    a_queue_bound : assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= 2'd2)
        else $error("result queue overflow");

    a_clear_once : assert property (@(posedge clk) disable iff (!rst_n)
        !clear_reg |=> !clear_reg)
        else $error("clearing pass restarted");

    a_clear_wrap : assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clear_reg) |-> clr_addr_reg == '0)
        else $error("clearing pass ended early");

    a_count_after_warm : assert property (@(posedge clk) disable iff (!rst_n)
        upd_write |-> warm_full)
        else $error("bin updated during warm-up");

    a_no_request_while_clear : assert property (@(posedge clk) disable iff (!rst_n)
        clear_reg |-> !e_valid_reg && occ_reg == 2'd0)
        else $error("request in flight during clearing pass");
`endif

endmodule

/* tb/bitcount_class_sequence_histogram_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bit-count class sequence histogram testbench
// Drives sample and read requests under random gaps and result stalls, keeps
// its own copy of the class history and the bin counts, and checks every
// result field by field against the predicted one.
// ----------------------------------------------------------------------------
module bitcount_class_sequence_histogram_tb;

    import bcsh_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000; // covers the RAM clear after reset
    localparam int DRAIN_CYCLES   = 6;     // covers the RAM read and update stages plus margin
    localparam int HOLD_CYCLES    = 300;   // long result hold-off
    localparam int PHASE_REQUESTS = 85;

    typedef struct packed {
        logic [11:0]           history_code;
        logic                  counted;
        logic [COUNT_BITS-1:0] bin_count;
    } bin_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  config_write;
    logic [TERMS_BITS-1:0] config_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [0:0]            operation;
    logic [31:0]           word;
    logic [11:0]           bin_index;
    logic                  out_valid;
    logic                  out_stall;
    logic [11:0]           history_code;
    logic                  counted;
    logic [COUNT_BITS-1:0] bin_count;

    // Mirror of the block state
    logic [TERMS_BITS-1:0] model_terms;
    logic [CODE_BITS-1:0]  model_history;
    int                    model_warm;
    logic [COUNT_BITS-1:0] model_bins [BINS];

    bin_result_t predicted_results [$];
    bin_result_t oldest_result;

    int mismatches;
    int quiet_cycles;
    bit hold_results;   // ask the result side for a long hold-off
    bit hold_active;    // the long hold-off is under way
    bit no_gaps;        // send back to back

    bitcount_class_sequence_histogram u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .config_write (config_write),
        .config_data  (config_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .word         (word),
        .bin_index    (bin_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .history_code (history_code),
        .counted      (counted),
        .bin_count    (bin_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Code window for a terms setting: zero behaves as one term, anything
    // above the maximum behaves as the maximum.
    function automatic logic [CODE_BITS-1:0] code_window(input logic [TERMS_BITS-1:0] t);
        int k;
        k = int'(t);
        if (k == 0)
            k = 1;
        if (k > MAX_TERMS)
            k = MAX_TERMS;
        return CODE_BITS'((1 << (LOG_BUCKETS * k)) - 1);
    endfunction

    function automatic class_t class_of_word(input logic [31:0] w);
        int ones;
        ones = $countones(w ^ {w[30:0], 1'b0});
        if (ones <= 14)
            return CLASS_LOW;
        else if (ones <= 17)
            return CLASS_MID;
        return CLASS_HIGH;
    endfunction

    // Advance the mirror by one accepted request and queue its result
    function automatic void apply_request(input op_t op, input logic [31:0] w,
                                          input logic [11:0] idx);
        bin_result_t r;
        r.counted   = 1'b0;
        r.bin_count = '0;
        if (op == OP_READ)
        begin
            r.bin_count = model_bins[idx[CODE_BITS-1:0]];
        end
        else
        begin
            model_history = ((model_history << LOG_BUCKETS) & code_window(model_terms))
                            | CODE_BITS'(class_of_word(w));
            if (model_warm < WARMUP_WORDS)
                model_warm++;
            else
            begin
                // hold at full scale
                if (model_bins[model_history] != COUNT_MAX)
                    model_bins[model_history] = model_bins[model_history] + 1'b1;
                r.counted = 1'b1;
            end
        end
        r.history_code = 12'(model_history);
        predicted_results.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Build a word whose w ^ (w << 1) has exactly n set bits: place the bits
    // of g at random, then undo the neighbor XOR from bit 0 upward.
    function automatic logic [31:0] word_with_ones(input int n);
        logic [31:0] g;
        logic [31:0] w;
        int placed;
        int pos;
        g = '0;
        placed = 0;
        while (placed < n)
        begin
            pos = $urandom_range(0, 31);
            if (!g[pos])
            begin
                g[pos] = 1'b1;
                placed++;
            end
        end
        w[0] = g[0];
        for (int i = 1; i < 32; i++)
            w[i] = g[i] ^ w[i-1];
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, want, got);
        mismatches++;
    endtask

    // Offer one request, hold it until taken, then maybe drop valid for a gap
    task automatic send_request(input op_t op, input logic [31:0] w,
                                input logic [11:0] idx);
        int gap;
        in_valid  <= 1'b1;
        operation <= op;
        word      <= w;
        bin_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_request(op, w, idx);
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and let every outstanding result drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_terms(input logic [TERMS_BITS-1:0] t);
        config_write <= 1'b1;
        config_data  <= t;
        @(posedge clk);
        model_terms = t;
        config_write <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Warm-up at the reset setting, class boundaries and word extremes
    task automatic test_warmup_and_classes();
        send_request(OP_SAMPLE, 32'h0000_0000, 12'h000);   // no transitions
        send_request(OP_SAMPLE, 32'hffff_ffff, 12'hfff);   // one set bit
        send_request(OP_SAMPLE, 32'h5555_5555, 12'h555);   // all 32 set
        send_request(OP_SAMPLE, 32'haaaa_aaaa, 12'haaa);   // last warm-up word
        send_request(OP_SAMPLE, word_with_ones(14), 12'h000);
        send_request(OP_SAMPLE, word_with_ones(15), 12'h000);
        send_request(OP_SAMPLE, word_with_ones(17), 12'h000);
        send_request(OP_SAMPLE, word_with_ones(18), 12'h000);
        send_request(OP_SAMPLE, 32'h0000_5555, 12'h000);   // sixteen, middle class
        send_request(OP_READ, 32'hffff_ffff, 12'(model_history));
        send_request(OP_READ, 32'h0000_0000, 12'hfff);
        send_request(OP_READ, 32'h1234_5678, 12'h000);
        wait_idle();
    endtask

    // Out-of-range terms values, and reads beyond the current code range
    task automatic test_terms_limits();
        set_terms(3'd0);
        send_request(OP_SAMPLE, word_with_ones(16), 12'h000);
        send_request(OP_SAMPLE, word_with_ones(0), 12'h000);
        send_request(OP_SAMPLE, word_with_ones(32), 12'h000);
        send_request(OP_READ, 32'h0, 12'h002);
        send_request(OP_READ, 32'h0, 12'(model_history));
        wait_idle();
        set_terms(3'd7);
        send_request(OP_SAMPLE, word_with_ones(20), 12'h000);
        send_request(OP_SAMPLE, word_with_ones(10), 12'h000);
        send_request(OP_READ, 32'h0, 12'(model_history));
        send_request(OP_READ, 32'h0, 12'hfff);
        send_request(OP_READ, 32'h0, 12'h002);
        wait_idle();
    endtask

    // Hold the result side off while requests keep coming back to back, so
    // the result queue fills and the request side has to stall.
    task automatic test_backpressure();
        set_terms(3'd2);
        hold_results = 1'b1;
        no_gaps      = 1'b1;
        wait (hold_active);
        repeat (40)
        begin
            if ($urandom_range(0, 3) == 0)
                send_request(OP_READ, $urandom, 12'($urandom_range(0, 15)));
            else
                send_request(OP_SAMPLE, $urandom, 12'($urandom));
        end
        no_gaps = 1'b0;
        wait_idle();
    endtask

    // Phases of random requests, each under its own terms setting; history
    // and counts carry over from one setting to the next.
    task automatic test_random_settings();
        logic [TERMS_BITS-1:0] plan [8] = '{3'd3, 3'd0, 3'd7, 3'd1, 3'd6, 3'd2, 3'd5, 3'd4};
        int r;
        foreach (plan[p])
        begin
            set_terms(plan[p]);
            repeat (PHASE_REQUESTS)
            begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    send_request(OP_SAMPLE, $urandom, 12'($urandom));
                else if (r < 72)
                    send_request(OP_SAMPLE, word_with_ones($urandom_range(12, 20)),
                                 12'($urandom));
                else if (r < 88)
                    // read inside the active code range, where counts pile up
                    send_request(OP_READ, $urandom,
                                 12'($urandom) & 12'(code_window(model_terms)));
                else
                    send_request(OP_READ, $urandom, 12'($urandom));
            end
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, plus the long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        int n;
        forever
        begin
            if (hold_results)
            begin
                out_stall <= 1'b1;
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
                hold_active  = 1'b0;
            end
            else
            begin
                n = pick_gap();
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    end

    // Check each taken result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (predicted_results.size() == 0)
                report_mismatch("unexpected result", 64'h0, 64'(history_code));
            else
            begin
                oldest_result = predicted_results.pop_front();
                if (history_code !== oldest_result.history_code)
                    report_mismatch("history_code", 64'(oldest_result.history_code),
                                    64'(history_code));
                if (counted !== oldest_result.counted)
                    report_mismatch("counted", 64'(oldest_result.counted), 64'(counted));
                if (bin_count !== oldest_result.bin_count)
                    report_mismatch("bin_count", 64'(oldest_result.bin_count),
                                    64'(bin_count));
            end
        end
    end

    // Watchdog: end the run when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        mismatches    = 0;
        quiet_cycles  = 0;
        hold_results  = 1'b0;
        hold_active   = 1'b0;
        no_gaps       = 1'b0;
        model_terms   = 3'd6;
        model_history = '0;
        model_warm    = 0;
        foreach (model_bins[i])
            model_bins[i] = '0;

        rst_n        <= 1'b0;
        config_write <= 1'b0;
        config_data  <= '0;
        in_valid     <= 1'b0;
        operation    <= OP_SAMPLE;
        word         <= '0;
        bin_index    <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_warmup_and_classes();
        test_terms_limits();
        test_backpressure();
        test_random_settings();

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hdl/bcsh_pkg.sv
hdl/bitcount_class_sequence_histogram.sv
tb/bitcount_class_sequence_histogram_tb.sv
